FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the filter RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/skf_pkg.sv
// Shared types, constants and helper functions of the scalar Kalman filter.
// Used by the channel interfaces, the arithmetic units and the top level.
package skf_pkg;

    // Word widths of the Q-format data paths.
    localparam int DATA_W = 32;
    localparam int MAG_W  = DATA_W + 1;
    localparam int FRAC_BITS_DEFAULT = 16;

    // Configuration port.
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INIT_EST   = 2'd0,
        CFG_INIT_VAR   = 2'd1,
        CFG_PROC_NOISE = 2'd2,
        CFG_MEAS_NOISE = 2'd3
    } skf_cfg_idx_t;

    // Reset values of the registers (1.0 in Q16.16 for the variances).
    localparam logic [DATA_W-1:0] INIT_EST_RESET   = 32'h0000_0000;
    localparam logic [DATA_W-1:0] INIT_VAR_RESET   = 32'h0001_0000;
    localparam logic [DATA_W-1:0] PROC_NOISE_RESET = 32'h0000_0000;
    localparam logic [DATA_W-1:0] MEAS_NOISE_RESET = 32'h0001_0000;

    // Clamp limits of the signed estimate.
    localparam logic [DATA_W-1:0] EST_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] EST_MIN = 32'h8000_0000;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SUM,
        ST_DIV,
        ST_MUL_EST,
        ST_MUL_VAR,
        ST_FINISH
    } skf_state_t;

    // Unsigned add that saturates at the top of the variance range.
    function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[DATA_W] ? {DATA_W{1'b1}} : sum[DATA_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/skf_meas_if.sv
// Measurement channel of the scalar Kalman filter: valid, ready and one reading.
// Depends on skf_pkg for the data width.
interface skf_meas_if;
    logic                               valid;
    logic                               ready;
    logic signed [skf_pkg::DATA_W-1:0]  measurement;

    modport source (output valid, output measurement, input ready);
    modport sink (input valid, input measurement, output ready);
endinterface

FILE: hw/rtl/skf_result_if.sv
// Result channel of the scalar Kalman filter: valid, ready and the filter state.
// Depends on skf_pkg for the data width.
interface skf_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [skf_pkg::DATA_W-1:0]  estimate;
    logic        [skf_pkg::DATA_W-1:0]  variance;
    logic                               update_skipped;

    modport source (output valid, output estimate, output variance, output update_skipped,
                    input ready);
    modport sink (input valid, input estimate, input variance, input update_skipped,
                  output ready);
endinterface

FILE: hw/rtl/skf_divider.sv
// Restoring divider for the Kalman gain: quotient bits of (numer << FRAC_BITS) / denom.
// One compare and subtract per cycle; depends on skf_pkg. Requires numer <= denom.
module skf_divider #(
    parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [skf_pkg::DATA_W-1:0]  numer,
    input  logic [skf_pkg::DATA_W-1:0]  denom,
    output logic                        done,
    output logic [FRAC_BITS:0]          quot
);

    localparam int Q_W   = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(Q_W + 1);
    localparam int DW    = skf_pkg::DATA_W;

    logic [DW:0]       rem_reg;
    logic [DW-1:0]     den_reg;
    logic [Q_W-1:0]    quot_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;

    logic              ge;
    logic [DW:0]       diff;
    logic [DW:0]       rem_sel;

    // Trial subtraction; the kept remainder stays below the divisor.
    always_comb
    begin
        ge      = (rem_reg >= {1'b0, den_reg});
        diff    = rem_reg - {1'b0, den_reg};
        rem_sel = ge ? diff : rem_reg;
    end

    // Control: step counter and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(Q_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Data: remainder and quotient, one bit per step.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {1'b0, numer};
            den_reg  <= denom;
            quot_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= {rem_sel[DW-1:0], 1'b0};
            quot_reg <= {quot_reg[Q_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

FILE: hw/rtl/skf_multiplier.sv
// Shift-and-add multiplier shared by the estimate and variance corrections.
// One conditional add per multiplier bit, LSB first; depends on skf_pkg.
module skf_multiplier #(
    parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic [skf_pkg::MAG_W-1:0]                 mcand,
    input  logic [FRAC_BITS:0]                        mplier,
    output logic                                      done,
    output logic [skf_pkg::MAG_W+FRAC_BITS+1:0]       prod
);

    localparam int B_W   = FRAC_BITS + 1;
    localparam int AW    = skf_pkg::MAG_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [AW:0]       hi_reg;
    logic [B_W-1:0]    lo_reg;
    logic [AW-1:0]     a_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;

    logic [AW:0]       sum;

    // Add the multiplicand when the current multiplier bit is set.
    always_comb
    begin
        sum = hi_reg + (lo_reg[0] ? {1'b0, a_reg} : '0);
    end

    // Control: step counter and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(B_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Data: the accumulator and multiplier shift right together.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg <= '0;
            lo_reg <= mplier;
            a_reg  <= mcand;
        end
        else if (cnt_reg != '0)
        begin
            hi_reg <= {1'b0, sum[AW:1]};
            lo_reg <= {sum[0], lo_reg[B_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

FILE: hw/rtl/scalar_kalman_filter.sv
// Top level of the one-dimensional Kalman filter in Q-format fixed point.
// Depends on skf_pkg, skf_meas_if, skf_result_if, skf_divider, skf_multiplier
// and assert_macros.svh.
//
//   Channel  Direction  Contents
//   meas     in         measurement (signed)
//   res      out        estimate (signed), variance, update_skipped
//   cfg_*    in         cfg_we, cfg_index, cfg_wdata (write only)
//
// Each item passes from acceptance through a preparation and a summing state, the
// bit-serial gain divider and then two passes through the shared shift-and-add
// multiplier; a new item is accepted only once the block is idle again. A zero
// innovation variance bypasses the arithmetic.
// Reset is asynchronous, active low; it loads the register reset values.
// A finished item waits in the output register; the block stalls before
// writing a new one until the previous item has been taken.
`include "assert_macros.svh"

module scalar_kalman_filter #(
    parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    skf_meas_if.sink                      meas,
    skf_result_if.source                  res,
    input  logic                          cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]    cfg_wdata
);

    localparam int DW  = skf_pkg::DATA_W;
    localparam int AW  = skf_pkg::MAG_W;
    localparam int Q_W = FRAC_BITS + 1;
    localparam int P_W = AW + 1 + Q_W;

    // Configuration and filter state.
    logic [DW-1:0]  init_est_reg;
    logic [DW-1:0]  init_var_reg;
    logic [DW-1:0]  proc_noise_reg;
    logic [DW-1:0]  meas_noise_reg;
    logic [DW-1:0]  cur_est_reg;
    logic [DW-1:0]  cur_var_reg;

    // Working registers of one item.
    skf_pkg::skf_state_t state_reg, state_next;
    logic [DW-1:0]  meas_reg;
    logic [DW-1:0]  p_reg;
    logic [DW:0]    d_reg;
    logic           neg_reg;
    logic [AW-1:0]  mag_reg;
    logic [Q_W-1:0] k_reg;
    logic [AW-1:0]  cmag_reg;
    logic           skip_reg;

    // Output register.
    logic           out_valid_reg;
    logic [DW-1:0]  out_est_reg;
    logic [DW-1:0]  out_var_reg;
    logic           out_skip_reg;

    // Sequencer strobes and unit connections.
    logic           in_take;
    logic           div_start;
    logic           div_done;
    logic [Q_W-1:0] div_quot;
    logic           mul_start;
    logic           mul_done;
    logic [AW-1:0]  mul_a;
    logic [Q_W-1:0] mul_b;
    logic [P_W-1:0] mul_prod;
    logic           load_out;

    // Derived arithmetic.
    logic [DW-1:0]  s_w;
    logic [P_W-1:0] prod_rnd;
    logic [AW-1:0]  cmag_w;
    logic [DW-1:0]  var_new;
    logic [Q_W-1:0] one_minus_k;
    logic [DW+1:0]  est_ext;
    logic [DW+1:0]  cmag_ext;
    logic [DW+1:0]  est_sum;
    logic [DW-1:0]  est_new;

    assign in_take = meas.valid && meas.ready;

    // Innovation variance, rounding of the product and the clamped estimate.
    always_comb
    begin
        s_w         = skf_pkg::sat_add(p_reg, meas_noise_reg);
        prod_rnd    = mul_prod + (P_W'(1) << (FRAC_BITS - 1));
        cmag_w      = prod_rnd[FRAC_BITS+AW-1:FRAC_BITS];
        var_new     = prod_rnd[FRAC_BITS+DW-1:FRAC_BITS];
        one_minus_k = (Q_W'(1) << FRAC_BITS) - k_reg;
        est_ext     = {{2{cur_est_reg[DW-1]}}, cur_est_reg};
        cmag_ext    = {1'b0, cmag_reg};
        est_sum     = neg_reg ? (est_ext - cmag_ext) : (est_ext + cmag_ext);
        if (est_sum[DW+1:DW-1] == 3'b000 || est_sum[DW+1:DW-1] == 3'b111)
        begin
            est_new = est_sum[DW-1:0];
        end
        else
        begin
            est_new = est_sum[DW+1] ? skf_pkg::EST_MIN : skf_pkg::EST_MAX;
        end
    end

    // Sequencer: next state and unit strobes.
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        mul_start  = 1'b0;
        mul_a      = {1'b0, p_reg};
        mul_b      = one_minus_k;
        load_out   = 1'b0;
        unique case (state_reg)
            skf_pkg::ST_IDLE:
            begin
                if (meas.valid)
                begin
                    state_next = skf_pkg::ST_PREP;
                end
            end
            skf_pkg::ST_PREP:
            begin
                state_next = skf_pkg::ST_SUM;
            end
            skf_pkg::ST_SUM:
            begin
                if (s_w == '0)
                begin
                    state_next = skf_pkg::ST_FINISH;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = skf_pkg::ST_DIV;
                end
            end
            skf_pkg::ST_DIV:
            begin
                mul_a = mag_reg;
                mul_b = div_quot;
                if (div_done)
                begin
                    mul_start  = 1'b1;
                    state_next = skf_pkg::ST_MUL_EST;
                end
            end
            skf_pkg::ST_MUL_EST:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    state_next = skf_pkg::ST_MUL_VAR;
                end
            end
            skf_pkg::ST_MUL_VAR:
            begin
                if (mul_done)
                begin
                    state_next = skf_pkg::ST_FINISH;
                end
            end
            skf_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    load_out   = 1'b1;
                    state_next = skf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = skf_pkg::ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers and the filter state; a write reloads the state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_est_reg   <= skf_pkg::INIT_EST_RESET;
            init_var_reg   <= skf_pkg::INIT_VAR_RESET;
            proc_noise_reg <= skf_pkg::PROC_NOISE_RESET;
            meas_noise_reg <= skf_pkg::MEAS_NOISE_RESET;
            cur_est_reg    <= skf_pkg::INIT_EST_RESET;
            cur_var_reg    <= skf_pkg::INIT_VAR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (skf_pkg::skf_cfg_idx_t'(cfg_index))
                skf_pkg::CFG_INIT_EST:
                begin
                    init_est_reg <= cfg_wdata;
                    cur_est_reg  <= cfg_wdata;
                    cur_var_reg  <= init_var_reg;
                end
                skf_pkg::CFG_INIT_VAR:
                begin
                    init_var_reg <= cfg_wdata;
                    cur_est_reg  <= init_est_reg;
                    cur_var_reg  <= cfg_wdata;
                end
                skf_pkg::CFG_PROC_NOISE:
                begin
                    proc_noise_reg <= cfg_wdata;
                    cur_est_reg    <= init_est_reg;
                    cur_var_reg    <= init_var_reg;
                end
                skf_pkg::CFG_MEAS_NOISE:
                begin
                    meas_noise_reg <= cfg_wdata;
                    cur_est_reg    <= init_est_reg;
                    cur_var_reg    <= init_var_reg;
                end
                default:
                begin
                    cur_est_reg <= init_est_reg;
                    cur_var_reg <= init_var_reg;
                end
            endcase
        end
        else if (state_reg == skf_pkg::ST_MUL_VAR && mul_done)
        begin
            cur_est_reg <= est_new;
            cur_var_reg <= var_new;
        end
    end

    // Working registers of the item in flight.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            meas_reg <= meas.measurement;
        end
        if (state_reg == skf_pkg::ST_PREP)
        begin
            p_reg <= skf_pkg::sat_add(cur_var_reg, proc_noise_reg);
            d_reg <= {meas_reg[DW-1], meas_reg} - {cur_est_reg[DW-1], cur_est_reg};
        end
        if (state_reg == skf_pkg::ST_SUM)
        begin
            neg_reg  <= d_reg[DW];
            mag_reg  <= d_reg[DW] ? (~d_reg + AW'(1)) : d_reg;
            skip_reg <= (s_w == '0);
        end
        if (state_reg == skf_pkg::ST_DIV && div_done)
        begin
            k_reg <= div_quot;
        end
        if (state_reg == skf_pkg::ST_MUL_EST && mul_done)
        begin
            cmag_reg <= cmag_w;
        end
    end

    // Output register: holds one finished item until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_est_reg  <= cur_est_reg;
            out_var_reg  <= cur_var_reg;
            out_skip_reg <= skip_reg;
        end
    end

    assign meas.ready         = (state_reg == skf_pkg::ST_IDLE);
    assign res.valid          = out_valid_reg;
    assign res.estimate       = out_est_reg;
    assign res.variance       = out_var_reg;
    assign res.update_skipped = out_skip_reg;

    // Gain divider and shared multiplier.
    skf_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (p_reg),
        .denom (s_w),
        .done  (div_done),
        .quot  (div_quot)
    );

    skf_multiplier #(
        .FRAC_BITS (FRAC_BITS)
    ) u_multiplier (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mcand  (mul_a),
        .mplier (mul_b),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    // A skipped update only happens with a zero variance.
    `ASSERT_ALWAYS(a_skip_zero_var, clk, rst_n, res.valid && res.update_skipped |-> res.variance == '0, "skipped update with nonzero variance")
    // The gain never exceeds one.
    `ASSERT_ALWAYS(a_gain_le_one, clk, rst_n, div_done |-> div_quot <= (Q_W'(1) << FRAC_BITS), "gain above one")
    // The updated variance never exceeds the predicted variance.
    `ASSERT_ALWAYS(a_var_shrinks, clk, rst_n, state_reg == skf_pkg::ST_MUL_VAR && mul_done |-> var_new <= p_reg, "updated variance above prediction")
    // An accepted item starts the sequencer.
    `ASSERT_NEXT(a_take_starts, clk, rst_n, in_take, state_reg == skf_pkg::ST_PREP, "accepted item did not start")

endmodule
